// File: src/emb_pkg.sv
// Shared types and constants of the emulated memory bus decoder.
// Depends on nothing; imported by every module of the block but emb_checker.
package emb_pkg;

    localparam int ROM_ADDR_BITS = 20;
    localparam int ROM_ROW_W     = ROM_ADDR_BITS - 2;
    localparam int ROM_ROWS      = 1 << ROM_ROW_W;

    localparam int RAM_ROW_W = 17;
    localparam int RAM_ROWS  = 99072;

    localparam logic [RAM_ROW_W-1:0] EWRAM_BASE = RAM_ROW_W'(0);
    localparam logic [RAM_ROW_W-1:0] VRAM_BASE  = RAM_ROW_W'(65536);
    localparam logic [RAM_ROW_W-1:0] IWRAM_BASE = RAM_ROW_W'(90112);
    localparam logic [RAM_ROW_W-1:0] OAM_BASE   = RAM_ROW_W'(98304);
    localparam logic [RAM_ROW_W-1:0] PAL_BASE   = RAM_ROW_W'(98560);
    localparam logic [RAM_ROW_W-1:0] IO_BASE    = RAM_ROW_W'(98816);

    localparam logic [15:0] EWRAM_ROW_MASK = 16'hFFFF;
    localparam logic [15:0] VRAM_ROW_MASK  = 16'h5FFF;
    localparam logic [15:0] IWRAM_ROW_MASK = 16'h1FFF;
    localparam logic [15:0] SMALL_ROW_MASK = 16'h00FF;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_LOAD  = 2'd2;

    localparam int ROM_LEN_W = 21;
    localparam int ROM_OFF_W = 25;

    typedef struct packed {
        logic                           rom_rd;
        logic                           rom_we;
        logic                           ram_rd;
        logic                           ram_we;
        logic                           ign;
        logic [1:0]                     low;
        logic [3:0][ROM_ROW_W-1:0]      rom_row;
        logic [3:0][RAM_ROW_W-1:0]      ram_row;
        logic [3:0][7:0]                wbyte;
    } t_access;

endpackage

// File: src/emb_decode.sv
// Address decoder: region select, per-lane row addresses and write lanes.
// Depends on emb_pkg.
module emb_decode import emb_pkg::*; (
    input  logic                 i_en,
    input  logic [1:0]           i_kind,
    input  logic [31:0]          i_address,
    input  logic [31:0]          i_wdata,
    input  logic [ROM_LEN_W-1:0] i_rom_len,
    output t_access              o_acc
);

    localparam logic [2:0] REG_BIOS  = 3'd0;
    localparam logic [2:0] REG_EWRAM = 3'd1;
    localparam logic [2:0] REG_IWRAM = 3'd2;
    localparam logic [2:0] REG_IO    = 3'd3;
    localparam logic [2:0] REG_PAL   = 3'd4;
    localparam logic [2:0] REG_VRAM  = 3'd5;
    localparam logic [2:0] REG_OAM   = 3'd6;
    localparam logic [2:0] REG_ROM   = 3'd7;

    logic [27:0]          addr;
    logic [2:0]           region;
    logic                 is_ram;
    logic [15:0]          row_mask;
    logic [RAM_ROW_W-1:0] row_base;
    logic [ROM_OFF_W:0]   rom_end;
    logic                 rom_inb;
    logic [1:0]           low;

    assign addr = i_address[27:0];
    assign low  = i_address[1:0];

    always_comb begin
        if (addr[27]) begin
            region = REG_ROM;
        end else begin
            unique case (addr[26:24])
                3'd7:    region = REG_OAM;
                3'd6:    region = REG_VRAM;
                3'd5:    region = REG_PAL;
                3'd4:    region = REG_IO;
                3'd3:    region = REG_IWRAM;
                3'd2:    region = REG_EWRAM;
                default: region = REG_BIOS;
            endcase
        end
    end

    always_comb begin
        is_ram   = 1'b1;
        row_mask = SMALL_ROW_MASK;
        row_base = EWRAM_BASE;
        unique case (region)
            REG_EWRAM: begin
                row_mask = EWRAM_ROW_MASK;
                row_base = EWRAM_BASE;
            end
            REG_IWRAM: begin
                row_mask = IWRAM_ROW_MASK;
                row_base = IWRAM_BASE;
            end
            REG_IO:    row_base = IO_BASE;
            REG_PAL:   row_base = PAL_BASE;
            REG_VRAM: begin
                row_mask = VRAM_ROW_MASK;
                row_base = VRAM_BASE;
            end
            REG_OAM:   row_base = OAM_BASE;
            default:   is_ram = 1'b0;
        endcase
    end

    assign rom_end = {1'b0, addr[ROM_OFF_W-1:0]} + (ROM_OFF_W+1)'(3);
    assign rom_inb = rom_end < (ROM_OFF_W+1)'(i_rom_len);

    always_comb begin
        logic        cy;
        logic [1:0]  sel;
        logic [15:0] row16;
        o_acc.rom_rd = i_en && (i_kind == KIND_READ) && (region == REG_ROM) && rom_inb;
        o_acc.rom_we = i_en && (i_kind == KIND_LOAD);
        o_acc.ram_rd = i_en && (i_kind == KIND_READ) && is_ram;
        o_acc.ram_we = i_en && (i_kind == KIND_WRITE) && is_ram;
        o_acc.ign    = (i_kind == KIND_WRITE) && !is_ram;
        o_acc.low    = low;
        for (int j = 0; j < 4; j++) begin
            cy    = 2'(j) < low;
            sel   = 2'(j) - low;
            row16 = ((addr[17:2] & row_mask) + 16'(cy)) & row_mask;
            o_acc.rom_row[j] = i_address[ROM_ADDR_BITS-1:2] + ROM_ROW_W'(cy);
            o_acc.ram_row[j] = row_base + {1'b0, row16};
            o_acc.wbyte[j]   = i_wdata[8*sel +: 8];
        end
    end

endmodule

// File: src/emb_rom_store.sv
// ROM byte store: four byte-lane memories with registered read.
// Depends on emb_pkg.
module emb_rom_store import emb_pkg::*; (
    input  logic            i_clk,
    input  t_access         i_acc,
    output logic [3:0][7:0] o_q
);

    genvar j;
    generate
        for (j = 0; j < 4; j++) begin : g_lane
            logic [7:0] r_mem [ROM_ROWS];
            logic [7:0] r_q;
            always_ff @(posedge i_clk) begin
                if (i_acc.rom_we) begin
                    r_mem[i_acc.rom_row[j]] <= i_acc.wbyte[j];
                end
                if (i_acc.rom_rd) begin
                    r_q <= r_mem[i_acc.rom_row[j]];
                end
            end
            assign o_q[j] = r_q;
        end
    endgenerate

endmodule

// File: src/emb_ram_store.sv
// Work RAM byte store: EWRAM, VRAM, IWRAM, OAM, palette and I/O rows in
// four byte-lane memories with registered read. Depends on emb_pkg.
module emb_ram_store import emb_pkg::*; (
    input  logic            i_clk,
    input  t_access         i_acc,
    output logic [3:0][7:0] o_q
);

    genvar j;
    generate
        for (j = 0; j < 4; j++) begin : g_lane
            logic [7:0] r_mem [RAM_ROWS];
            logic [7:0] r_q;
            always_ff @(posedge i_clk) begin
                if (i_acc.ram_we) begin
                    r_mem[i_acc.ram_row[j]] <= i_acc.wbyte[j];
                end
                if (i_acc.ram_rd) begin
                    r_q <= r_mem[i_acc.ram_row[j]];
                end
            end
            assign o_q[j] = r_q;
        end
    endgenerate

endmodule

// File: src/emulated_memory_bus_decoder.sv
// Top level of the emulated memory bus decoder.
// Depends on emb_pkg, emb_decode, emb_rom_store and emb_ram_store.
//
// Takes one read, write or ROM-load transaction per cycle while the output
// is not stalled, and returns one result for each, through the registered
// read of the byte-lane memories and then the output register. Each region
// is four byte lanes wide, so a four-byte access, wrapped inside its
// region, reaches all its bytes in a single memory access. A location
// reads back valid only after it was written; there is no clearing pass
// after reset. Write the ROM length register only while idle.
module emulated_memory_bus_decoder import emb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [63:0]          s_tdata,   // address[31:0], write_data[63:32]
    input  logic [1:0]           s_tuser,   // kind[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // read_data[31:0]
    output logic                 m_tuser,   // write_ignored[0]
    input  logic                 i_cfg_we,
    input  logic [ROM_LEN_W-1:0] i_cfg_wdata
);

    logic [ROM_LEN_W-1:0]  r_rom_len;
    logic                  accept;
    t_access               acc;
    logic [3:0][7:0]       rom_q;
    logic [3:0][7:0]       ram_q;

    logic                  r_s1_valid;
    logic                  r_s1_rom;
    logic                  r_s1_ram;
    logic                  r_s1_ign;
    logic [1:0]            r_s1_low;

    logic                  r_out_valid;
    logic [31:0]           r_out_data;
    logic                  r_out_ign;

    logic                  out_free;
    logic                  s1_move;
    logic [3:0][7:0]       lanes;
    logic [31:0]           n_out_data;

    assign out_free = !r_out_valid || m_tready;
    assign s1_move  = r_s1_valid && out_free;
    assign s_tready = !r_s1_valid || s1_move;
    assign accept   = s_tvalid && s_tready;

    emb_decode u_decode (
        .i_en       (accept),
        .i_kind     (s_tuser),
        .i_address  (s_tdata[31:0]),
        .i_wdata    (s_tdata[63:32]),
        .i_rom_len  (r_rom_len),
        .o_acc      (acc)
    );

    emb_rom_store u_rom (
        .i_clk (i_clk),
        .i_acc (acc),
        .o_q   (rom_q)
    );

    emb_ram_store u_ram (
        .i_clk (i_clk),
        .i_acc (acc),
        .o_q   (ram_q)
    );

    always_comb begin
        lanes = r_s1_rom ? rom_q : ram_q;
        for (int k = 0; k < 4; k++) begin
            n_out_data[8*k +: 8] = lanes[r_s1_low + 2'(k)];
        end
        if (!r_s1_rom && !r_s1_ram) begin
            n_out_data = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_len <= '0;
        end else if (i_cfg_we) begin
            r_rom_len <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_rom <= acc.rom_rd;
            r_s1_ram <= acc.ram_rd;
            r_s1_ign <= acc.ign;
            r_s1_low <= acc.low;
        end
        if (s1_move) begin
            r_out_data <= n_out_data;
            r_out_ign  <= r_s1_ign;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;
    assign m_tuser  = r_out_ign;

endmodule

// File: src/emb_checker.sv
// Port-level checker for the emulated memory bus decoder, with its bind.
// Depends on emulated_memory_bus_decoder.
module emb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_ign_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser |-> m_tdata == 32'd0)
        else $error("ignored write carries read data");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind emulated_memory_bus_decoder emb_checker u_emb_checker (.*);
